// File: src/smc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smc_pkg: shared types and constants for the sprite mask collision block
// Sizes, register map, stream packing, control structs and mask helpers.
// ----------------------------------------------------------------------------
package smc_pkg;

   localparam int PLAYER_SIZE        = 16;
   localparam int OBSTACLE_MAX_WIDTH = 64;
   localparam int LANE_WIDTH         = 16;
   localparam int NUM_LANES          = OBSTACLE_MAX_WIDTH / LANE_WIDTH;
   localparam int PIDX_W             = $clog2(PLAYER_SIZE);

   // result queue, depth a power of two
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam int ROW_W      = 8;
   localparam int BITS_W     = 64;
   localparam int REQ_DATA_W = ROW_W + BITS_W;
   localparam int RSP_DATA_W = 8;

   localparam int POS_W  = 11;
   localparam int PW_W   = 5;
   localparam int OW_W   = 7;
   localparam int OH_W   = 9;
   localparam int DIFF_W = POS_W + 1;
   localparam int PROW_W = POS_W + 2;
   localparam int COL_W  = 7;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   localparam logic [REG_IDX_W-1:0] REG_PLAYER_X   = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_PLAYER_Y   = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_PLAYER_W   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_PLAYER_H   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_OBSTACLE_X = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_OBSTACLE_Y = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_OBSTACLE_W = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_OBSTACLE_H = 3'd7;

   localparam logic MODE_PLAYER   = 1'b0;
   localparam logic MODE_OBSTACLE = 1'b1;

   typedef struct packed {
      logic [POS_W-1:0] px;
      logic [POS_W-1:0] py;
      logic [PW_W-1:0]  pw;
      logic [PW_W-1:0]  ph;
      logic [POS_W-1:0] ox;
      logic [POS_W-1:0] oy;
      logic [OW_W-1:0]  ow;
      logic [OH_W-1:0]  oh;
   } cfg_type;

   typedef struct packed {
      logic valid;
      logic emit;
   } ctl_type;

   function automatic logic [PLAYER_SIZE-1:0] player_mask_of(input logic [PW_W-1:0] n);
      logic [PLAYER_SIZE-1:0] m;
      for (int i = 0; i < PLAYER_SIZE; i++) begin
         m[i] = (PW_W'(i) < n);
      end
      return m;
   endfunction

   function automatic logic [BITS_W-1:0] obstacle_mask_of(input logic [OW_W-1:0] n);
      logic [BITS_W-1:0] m;
      for (int i = 0; i < BITS_W; i++) begin
         m[i] = (OW_W'(i) < n);
      end
      return m;
   endfunction

endpackage
`default_nettype wire

// File: src/sprite_mask_collision_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sprite_mask_collision_top: pixel-exact player / obstacle sprite collision
// Usage: write positions and sizes on the csr_ port while idle. Send player
// mask rows (req_tuser = 0) first, then obstacle rows (req_tuser = 1) with
// req_tlast on the final row of the obstacle. Each obstacle row is tested
// against the overlapping player row, upper bounds exclusive, across four
// 16-column lanes; any common opaque pixel sets a sticky hit. The last row
// returns one rsp_ beat with the hit and clears it.
// Throughput: one row beat per cycle while req_tready is high. Path: the
// last row passes the input register (at the edge that accepts it), the
// lane register and the result queue before rsp_tvalid rises.
// Stall: results wait in a four-entry queue; req_tready drops only while
// four results are accepted but not yet taken, so a stalled receiver holds
// the input back after four frames.
// Reset: CSR registers return to their reset values, the sticky hit and queue
// clear. The player mask holds no defined value until each row is written.
// ----------------------------------------------------------------------------
module sprite_mask_collision_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // row_index [7:0], row_bits [71:8]
   input  wire logic [smc_pkg::REQ_DATA_W-1:0]     req_tdata,
   // mode
   input  wire logic                               req_tuser,
   input  wire logic                               req_tlast,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // hit [0], zero fill above
   output logic      [smc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [smc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [smc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic      [smc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                    csr_pready
);

   smc_pkg::cfg_type                       cfg;
   logic                                   accept, rsp_pop, rsp_hit;
   logic [smc_pkg::ROW_W-1:0]              row;
   logic [smc_pkg::BITS_W-1:0]             bits;
   logic [smc_pkg::PROW_W-1:0]             prow;
   logic                                   in_rows;
   logic [smc_pkg::DIFF_W-1:0]             diff;
   logic [smc_pkg::FIFO_CNT_W-1:0]         pending_ff, pending_in;
   logic [smc_pkg::PLAYER_SIZE-1:0]        pmask_ff [smc_pkg::PLAYER_SIZE];
   logic [smc_pkg::PLAYER_SIZE-1:0]        a_pbits_ff, a_pbits_in;
   logic [smc_pkg::BITS_W-1:0]             a_obits_ff;
   smc_pkg::ctl_type                       a_ctl_ff, a_ctl_in, b_ctl_ff;
   logic [smc_pkg::NUM_LANES-1:0]          lane_hit;

   smc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign accept  = req_tvalid & req_tready;
   assign rsp_pop = rsp_tvalid & rsp_tready;
   assign row     = req_tdata[smc_pkg::ROW_W-1:0];
   assign bits    = req_tdata[smc_pkg::REQ_DATA_W-1:smc_pkg::ROW_W];

   // results accepted and not yet taken
   assign req_tready = (pending_ff < smc_pkg::FIFO_CNT_W'(smc_pkg::FIFO_DEPTH));
   assign pending_in = pending_ff
                     + smc_pkg::FIFO_CNT_W'(accept & req_tuser & req_tlast)
                     - smc_pkg::FIFO_CNT_W'(rsp_pop);

   // player row under this obstacle row
   always_comb begin
      prow = {{2{cfg.oy[smc_pkg::POS_W-1]}}, cfg.oy}
           + smc_pkg::PROW_W'(row)
           - {{2{cfg.py[smc_pkg::POS_W-1]}}, cfg.py};
      in_rows = (smc_pkg::OH_W'(row) < cfg.oh)
              & (prow < smc_pkg::PROW_W'(cfg.ph));
      a_pbits_in = '0;
      if (in_rows) begin
         a_pbits_in = pmask_ff[prow[smc_pkg::PIDX_W-1:0]]
                    & smc_pkg::player_mask_of(cfg.pw);
      end
      a_ctl_in.valid = accept & (req_tuser == smc_pkg::MODE_OBSTACLE);
      a_ctl_in.emit  = req_tlast;
   end

   assign diff = {cfg.px[smc_pkg::POS_W-1], cfg.px} - {cfg.ox[smc_pkg::POS_W-1], cfg.ox};

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         a_ctl_ff   <= '0;
         b_ctl_ff   <= '0;
      end else begin
         pending_ff <= pending_in;
         a_ctl_ff   <= a_ctl_in;
         b_ctl_ff   <= a_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_pbits_ff <= a_pbits_in;
      a_obits_ff <= bits & smc_pkg::obstacle_mask_of(cfg.ow);
      if (accept && (req_tuser == smc_pkg::MODE_PLAYER) &&
          (row < smc_pkg::ROW_W'(smc_pkg::PLAYER_SIZE))) begin
         pmask_ff[row[smc_pkg::PIDX_W-1:0]] <= bits[smc_pkg::PLAYER_SIZE-1:0];
      end
   end

   for (genvar g = 0; g < smc_pkg::NUM_LANES; g++) begin : g_lane
      smc_lane u_lane (
         .clock (clock),
         .base  (smc_pkg::COL_W'(g * smc_pkg::LANE_WIDTH)),
         .diff  (diff),
         .pbits (a_pbits_ff),
         .obits (a_obits_ff[g*smc_pkg::LANE_WIDTH +: smc_pkg::LANE_WIDTH]),
         .hit   (lane_hit[g])
      );
   end

   smc_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .ctl        (b_ctl_ff),
      .lane_hit   (lane_hit),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_hit    (rsp_hit)
   );

   assign rsp_tdata = smc_pkg::RSP_DATA_W'(rsp_hit);

`ifndef ASSERT_OFF
   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= smc_pkg::FIFO_CNT_W'(smc_pkg::FIFO_DEPTH))
      else $error("result count above queue depth");

   a_result_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (pending_ff != '0))
      else $error("result beat shown with no result pending");

   a_player_no_test: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_tuser == smc_pkg::MODE_PLAYER)) |=> !a_ctl_ff.valid)
      else $error("player row entered the test pipeline");
`endif

endmodule
`default_nettype wire

// File: src/smc_csr.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smc_csr: configuration register file
// APB-style sprite position/size registers; widths and player height clamped.
// ----------------------------------------------------------------------------
module smc_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [smc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [smc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [smc_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                  csr_pready,
   output smc_pkg::cfg_type                      cfg
);

   logic [smc_pkg::POS_W-1:0]     px_ff, py_ff, ox_ff, oy_ff;
   logic [smc_pkg::PW_W-1:0]      pw_ff, ph_ff;
   logic [smc_pkg::OW_W-1:0]      ow_ff;
   logic [smc_pkg::OH_W-1:0]      oh_ff;
   logic [smc_pkg::REG_IDX_W-1:0] idx;
   logic                          wr_en;

   assign csr_pready = 1'b1;
   assign idx        = csr_paddr[smc_pkg::CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         px_ff <= '0;
         py_ff <= '0;
         pw_ff <= smc_pkg::PW_W'(8);
         ph_ff <= smc_pkg::PW_W'(8);
         ox_ff <= '0;
         oy_ff <= '0;
         ow_ff <= smc_pkg::OW_W'(1);
         oh_ff <= smc_pkg::OH_W'(1);
      end else if (wr_en) begin
         unique case (idx)
            smc_pkg::REG_PLAYER_X:   px_ff <= csr_pwdata[smc_pkg::POS_W-1:0];
            smc_pkg::REG_PLAYER_Y:   py_ff <= csr_pwdata[smc_pkg::POS_W-1:0];
            smc_pkg::REG_PLAYER_W:   pw_ff <= csr_pwdata[smc_pkg::PW_W-1:0];
            smc_pkg::REG_PLAYER_H:   ph_ff <= csr_pwdata[smc_pkg::PW_W-1:0];
            smc_pkg::REG_OBSTACLE_X: ox_ff <= csr_pwdata[smc_pkg::POS_W-1:0];
            smc_pkg::REG_OBSTACLE_Y: oy_ff <= csr_pwdata[smc_pkg::POS_W-1:0];
            smc_pkg::REG_OBSTACLE_W: ow_ff <= csr_pwdata[smc_pkg::OW_W-1:0];
            smc_pkg::REG_OBSTACLE_H: oh_ff <= csr_pwdata[smc_pkg::OH_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (idx)
         smc_pkg::REG_PLAYER_X:   csr_prdata = smc_pkg::CSR_DATA_W'(px_ff);
         smc_pkg::REG_PLAYER_Y:   csr_prdata = smc_pkg::CSR_DATA_W'(py_ff);
         smc_pkg::REG_PLAYER_W:   csr_prdata = smc_pkg::CSR_DATA_W'(pw_ff);
         smc_pkg::REG_PLAYER_H:   csr_prdata = smc_pkg::CSR_DATA_W'(ph_ff);
         smc_pkg::REG_OBSTACLE_X: csr_prdata = smc_pkg::CSR_DATA_W'(ox_ff);
         smc_pkg::REG_OBSTACLE_Y: csr_prdata = smc_pkg::CSR_DATA_W'(oy_ff);
         smc_pkg::REG_OBSTACLE_W: csr_prdata = smc_pkg::CSR_DATA_W'(ow_ff);
         smc_pkg::REG_OBSTACLE_H: csr_prdata = smc_pkg::CSR_DATA_W'(oh_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   // effective sizes, widths and player height clamped when oversize
   always_comb begin
      cfg.px = px_ff;
      cfg.py = py_ff;
      cfg.ox = ox_ff;
      cfg.oy = oy_ff;
      cfg.oh = oh_ff;
      cfg.pw = (pw_ff > smc_pkg::PW_W'(smc_pkg::PLAYER_SIZE)) ?
               smc_pkg::PW_W'(smc_pkg::PLAYER_SIZE) : pw_ff;
      cfg.ph = (ph_ff > smc_pkg::PW_W'(smc_pkg::PLAYER_SIZE)) ?
               smc_pkg::PW_W'(smc_pkg::PLAYER_SIZE) : ph_ff;
      cfg.ow = (ow_ff > smc_pkg::OW_W'(smc_pkg::OBSTACLE_MAX_WIDTH)) ?
               smc_pkg::OW_W'(smc_pkg::OBSTACLE_MAX_WIDTH) : ow_ff;
   end

endmodule
`default_nettype wire

// File: src/smc_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smc_lane: one slice of obstacle columns
// Aligns the player row onto this slice and flags any common opaque pixel.
// ----------------------------------------------------------------------------
module smc_lane (
   input  wire logic                               clock,
   input  wire logic [smc_pkg::COL_W-1:0]          base,
   input  wire logic [smc_pkg::DIFF_W-1:0]         diff,
   input  wire logic [smc_pkg::PLAYER_SIZE-1:0]    pbits,
   input  wire logic [smc_pkg::LANE_WIDTH-1:0]     obits,
   output logic                                    hit
);

   logic [smc_pkg::LANE_WIDTH-1:0] aligned;
   logic                           hit_ff;
   logic                           hit_in;

   // player column seen at each obstacle column of the slice
   always_comb begin
      logic [smc_pkg::COL_W-1:0]  col;
      logic [smc_pkg::PROW_W-1:0] j;
      for (int i = 0; i < smc_pkg::LANE_WIDTH; i++) begin
         col = base + smc_pkg::COL_W'(i);
         j   = smc_pkg::PROW_W'(col) - {diff[smc_pkg::DIFF_W-1], diff};
         if (j < smc_pkg::PROW_W'(smc_pkg::PLAYER_SIZE)) begin
            aligned[i] = pbits[j[smc_pkg::PIDX_W-1:0]];
         end else begin
            aligned[i] = 1'b0;
         end
      end
      hit_in = |(aligned & obits);
   end

   always_ff @(posedge clock) begin
      hit_ff <= hit_in;
   end

   assign hit = hit_ff;

endmodule
`default_nettype wire

// File: src/smc_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smc_merge: lane merge, sticky hit and result queue
// ORs the lane flags, keeps the sticky hit and queues one result per frame.
// ----------------------------------------------------------------------------
module smc_merge (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire smc_pkg::ctl_type                  ctl,
   input  wire logic [smc_pkg::NUM_LANES-1:0]     lane_hit,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic                                   rsp_hit
);

   logic                            sticky_ff, sticky_in;
   logic                            fifo_ff [smc_pkg::FIFO_DEPTH];
   logic [smc_pkg::FIFO_PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [smc_pkg::FIFO_CNT_W-1:0]  count_ff, count_in;
   logic                            push, pop, row_hit;

   assign row_hit = |lane_hit;
   assign push    = ctl.valid & ctl.emit;
   assign pop     = rsp_tvalid & rsp_tready;

   always_comb begin
      sticky_in = sticky_ff;
      if (ctl.valid) begin
         sticky_in = ctl.emit ? 1'b0 : (sticky_ff | row_hit);
      end
      count_in = count_ff + smc_pkg::FIFO_CNT_W'(push) - smc_pkg::FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sticky_ff <= 1'b0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         sticky_ff <= sticky_in;
         count_ff  <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= sticky_ff | row_hit;
      end
   end

   assign rsp_tvalid = (count_ff != '0);
   assign rsp_hit    = fifo_ff[rd_ptr_ff];

endmodule
`default_nettype wire

// File: tb/sprite_mask_collision_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_mask_collision_top_test: self-checking bench for the sprite collision
// Loads player mask rows, streams obstacle frames under many sprite
// geometries and checks every hit beat against an in-bench collision
// predictor. Sender and receiver idle at random, and one long receiver stall
// backs the result queue up into the row input.
// ----------------------------------------------------------------------------
module sprite_mask_collision_top_test;
   import smc_pkg::*;

   class sprite_hit_model;
      logic [PLAYER_SIZE-1:0] player_rows [PLAYER_SIZE];
      logic sticky_hit;
      logic signed [POS_W-1:0] px, py, ox, oy;
      logic [PW_W-1:0] pw, ph;
      logic [OW_W-1:0] ow;
      logic [OH_W-1:0] oh;
      bit pending_hits [$];
      int mismatches, rows_taken, hits_seen, misses_seen;

      function new();
         foreach (player_rows[i]) player_rows[i] = '0;
         sticky_hit = 1'b0;
         px = '0; py = '0; ox = '0; oy = '0;
         pw = 8; ph = 8; ow = 1; oh = 1;
         mismatches = 0; rows_taken = 0; hits_seen = 0; misses_seen = 0;
      endfunction

      function logic [BITS_W-1:0] low_bits(input int n);
         return (n >= BITS_W) ? '1 : ((64'd1 << n) - 64'd1);
      endfunction

      function void set_reg(input logic [REG_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_PLAYER_X:   px = value[POS_W-1:0];
            REG_PLAYER_Y:   py = value[POS_W-1:0];
            REG_PLAYER_W:   pw = value[PW_W-1:0];
            REG_PLAYER_H:   ph = value[PW_W-1:0];
            REG_OBSTACLE_X: ox = value[POS_W-1:0];
            REG_OBSTACLE_Y: oy = value[POS_W-1:0];
            REG_OBSTACLE_W: ow = value[OW_W-1:0];
            REG_OBSTACLE_H: oh = value[OH_W-1:0];
            default: ;
         endcase
      endfunction

      function void take_row(input logic mode, input logic [ROW_W-1:0] row,
                             input logic [BITS_W-1:0] bits, input logic last);
         int pw_eff, ph_eff, ow_eff, prow, shift;
         logic [BITS_W-1:0] pbits, obits, aligned;
         rows_taken++;
         if (mode == MODE_PLAYER) begin
            if (row < PLAYER_SIZE) player_rows[row] = bits[PLAYER_SIZE-1:0];
            return;
         end
         if (row < oh) begin
            pw_eff = (pw > PLAYER_SIZE) ? PLAYER_SIZE : pw;
            ph_eff = (ph > PLAYER_SIZE) ? PLAYER_SIZE : ph;
            ow_eff = (ow > OBSTACLE_MAX_WIDTH) ? OBSTACLE_MAX_WIDTH : ow;
            prow = int'(oy) + int'(row) - int'(py);
            if (prow >= 0 && prow < ph_eff) begin
               pbits = BITS_W'(player_rows[prow]) & low_bits(pw_eff);
               obits = bits & low_bits(ow_eff);
               // obstacle column that player column 0 lands on
               shift = int'(px) - int'(ox);
               aligned = '0;
               if (shift >= 0 && shift < BITS_W) aligned = pbits << shift;
               else if (shift < 0 && shift > -BITS_W) aligned = pbits >> (-shift);
               if ((aligned & obits) != '0) sticky_hit = 1'b1;
            end
         end
         if (last) begin
            pending_hits.push_back(sticky_hit);
            sticky_hit = 1'b0;
         end
      endfunction

      function void check_hit(input logic [RSP_DATA_W-1:0] data);
         bit want;
         if (pending_hits.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected hit beat: hit=%b", data[0]);
            return;
         end
         want = pending_hits.pop_front();
         if (want) hits_seen++;
         else misses_seen++;
         if (data[0] !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("hit mismatch at %0t: expected %b, got %b", $realtime, want, data[0]);
         end
      endfunction
   endclass

   localparam int HOLD_LEN = 400;

   logic clock, reset;
   logic req_tvalid, req_tready, req_tuser, req_tlast;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic rsp_tvalid, rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata, csr_prdata;

   sprite_hit_model hit_model;
   int send_idle_pct, recv_idle_pct;
   int holds_asked, holds_served, hold_left;
   int geometries;

   sprite_mask_collision_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: random stalls, plus a long hold-off when one is asked for
   always @(negedge clock) begin
      if (holds_served != holds_asked) begin
         holds_served = holds_asked;
         hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready = 1'b0;
      end else begin
         rsp_tready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) hit_model.check_hit(rsp_tdata);
   end

   task automatic send_row(input logic mode, input logic [ROW_W-1:0] row,
                           input logic [BITS_W-1:0] bits, input logic last);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = mode;
      req_tdata = {bits, row};
      req_tlast = last;
      do @(posedge clock); while (req_tready !== 1'b1);
      hit_model.take_row(mode, row, bits, last);
   endtask

   // drop valid and wait until every hit beat is back and the pipe is empty
   task automatic settle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (hit_model.pending_hits.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = {idx, 2'b00};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      hit_model.set_reg(idx, value);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   task automatic load_geometry(input int px, input int py, input int pw, input int ph,
                                input int ox, input int oy, input int ow, input int oh);
      settle();
      geometries++;
      write_reg(REG_PLAYER_X, px & 32'h7FF);
      write_reg(REG_PLAYER_Y, py & 32'h7FF);
      write_reg(REG_PLAYER_W, pw);
      write_reg(REG_PLAYER_H, ph);
      write_reg(REG_OBSTACLE_X, ox & 32'h7FF);
      write_reg(REG_OBSTACLE_Y, oy & 32'h7FF);
      write_reg(REG_OBSTACLE_W, ow);
      write_reg(REG_OBSTACLE_H, oh);
   endtask

   function automatic logic [BITS_W-1:0] pick_bits();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2: return 64'd1 << $urandom_range(63);
         3, 4: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic random_block(input int quota);
      int sent, n, start, px, py, pw, ph, ox, oy, ow, oh;
      logic [ROW_W-1:0] row;
      pw = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(1, 16);
      ph = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(1, 16);
      ow = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(1, 64);
      oh = ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(1, 24);
      if ($urandom_range(9) == 0) begin
         px = $urandom_range(2047) - 1024;
         py = $urandom_range(2047) - 1024;
         ox = $urandom_range(2047) - 1024;
         oy = $urandom_range(2047) - 1024;
      end else begin
         px = $urandom_range(200) - 100;
         py = $urandom_range(200) - 100;
         ox = px + $urandom_range(100) - 70;
         oy = py + $urandom_range(40) - 24;
      end
      load_geometry(px, py, pw, ph, ox, oy, ow, oh);
      sent = 0;
      while (sent < quota) begin
         if ($urandom_range(99) < 30) begin
            n = $urandom_range(1, 3);
            repeat (n) begin
               row = ($urandom_range(9) == 0) ? ROW_W'($urandom_range(16, 255))
                                              : ROW_W'($urandom_range(15));
               send_row(MODE_PLAYER, row, {$urandom, $urandom}, $urandom_range(1));
               if (row < PLAYER_SIZE) sent++;
            end
         end
         n = ($urandom_range(9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 6);
         start = $urandom_range(oh + 2);
         for (int k = 0; k < n; k++) begin
            row = ($urandom_range(9) == 0) ? ROW_W'($urandom_range(255)) : ROW_W'(start + k);
            send_row(MODE_OBSTACLE, row, pick_bits(), k == n - 1);
         end
         sent += n;
      end
   endtask

   initial begin
      #5_000_000;
      $display("sprite_mask_collision_top: mismatch");
      $finish;
   end

   initial begin
      hit_model = new();
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = MODE_PLAYER;
      req_tlast = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      send_idle_pct = 35;
      recv_idle_pct = 63;
      holds_asked = 0;
      holds_served = 0;
      hold_left = 0;
      geometries = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // every player row written before any obstacle row reads one
      for (int i = 0; i < PLAYER_SIZE; i++) begin
         send_row(MODE_PLAYER, ROW_W'(i),
                  (i == 0 || i == PLAYER_SIZE - 1) ? '1 : (i == 1) ? '0 : {$urandom, $urandom},
                  1'b0);
      end
      // out-of-range player row carrying a last mark
      send_row(MODE_PLAYER, 8'd255, '1, 1'b1);
      // reset geometry, then a row below the obstacle that still emits
      send_row(MODE_OBSTACLE, 8'd0, '1, 1'b0);
      send_row(MODE_OBSTACLE, 8'd1, '1, 1'b1);
      // full sizes
      load_geometry(0, 0, 16, 16, 0, 0, 64, 256);
      send_row(MODE_OBSTACLE, 8'd15, '1, 1'b0);
      send_row(MODE_OBSTACLE, 8'd255, '1, 1'b1);
      // zero player width, zero obstacle width, zero obstacle height
      load_geometry(0, 0, 0, 16, 0, 0, 64, 16);
      send_row(MODE_OBSTACLE, 8'd0, '1, 1'b1);
      load_geometry(0, 0, 16, 16, 0, 0, 0, 16);
      send_row(MODE_OBSTACLE, 8'd0, '1, 1'b1);
      load_geometry(0, 0, 16, 16, 0, 0, 64, 0);
      send_row(MODE_OBSTACLE, 8'd0, '1, 1'b1);
      // oversize registers
      load_geometry(0, 0, 31, 31, 0, 0, 127, 511);
      send_row(MODE_OBSTACLE, 8'd0, '1, 1'b0);
      send_row(MODE_OBSTACLE, 8'd255, '1, 1'b1);
      // single-pixel corner overlap
      load_geometry(10, 10, 16, 16, 25, 25, 1, 1);
      send_row(MODE_OBSTACLE, 8'd0, '1, 1'b1);
      // position extremes, far apart
      load_geometry(-1024, -1024, 16, 16, 1023, 1023, 64, 256);
      send_row(MODE_OBSTACLE, 8'd0, '1, 1'b1);
      // largest shifts either way
      load_geometry(0, 0, 16, 16, -63, 0, 64, 16);
      send_row(MODE_OBSTACLE, 8'd0, '1, 1'b1);
      load_geometry(0, 0, 16, 16, 63, 0, 64, 16);
      send_row(MODE_OBSTACLE, 8'd0, '1, 1'b1);

      repeat (4) random_block(42);
      settle();
      send_idle_pct = 63;
      recv_idle_pct = 35;
      repeat (4) random_block(42);
      settle();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      holds_asked++;
      repeat (4) random_block(42);

      settle();
      $display("%0d row beats over %0d geometries, %0d hit beats checked (%0d hits, %0d clear)",
               hit_model.rows_taken, geometries, hit_model.hits_seen + hit_model.misses_seen,
               hit_model.hits_seen, hit_model.misses_seen);
      $display("three idle mixes and one long result stall; %0d mismatches",
               hit_model.mismatches);
      if (hit_model.mismatches == 0) begin
         $display("sprite_mask_collision_top: match");
      end else begin
         $display("sprite_mask_collision_top: mismatch");
      end
      $finish;
   end

endmodule
